>>> rtl/smd_pkg.sv
// Package for the serial message deframer: shared types, codes and characters.
// No dependencies; used by smd_parser and serial_message_deframer_core.
`default_nettype none

package smd_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_BRACE   = 2'd1,
        MODE_HEADER  = 2'd2,
        MODE_PAYLOAD = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_ID      = 2'd0,
        PH_SKIP_ID = 2'd1,
        PH_SIZE    = 2'd2,
        PH_SKIP_SZ = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OVERFLOW   = 2'd1,
        ST_BAD_HEADER = 2'd2
    } t_status;

    localparam logic [7:0] CH_LBRACE = 8'h7B; // '{'
    localparam logic [7:0] CH_RBRACE = 8'h7D; // '}'
    localparam logic [7:0] CH_LT     = 8'h3C; // '<'
    localparam logic [7:0] CH_GT     = 8'h3E; // '>'
    localparam logic [7:0] CH_COMMA  = 8'h2C; // ','
    localparam logic [7:0] CH_ZERO   = 8'h30; // '0'
    localparam logic [7:0] CH_NINE   = 8'h39; // '9'

    localparam logic [7:0] MAX_LENGTH_RST = 8'd250;
    localparam logic [7:0] SLOT_COUNT_RST = 8'd4;

    localparam logic REG_MAX_LENGTH = 1'b0;
    localparam logic REG_SLOT_COUNT = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_data;
        logic       headered;
        logic [7:0] conn_id;
        t_status    status;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/smd_parser.sv
// Deframer state machine: per-word mode, header parsing and result decode.
// Depends on smd_pkg.
`default_nettype none

module smd_parser
    import smd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_rx_byte,
    input  wire logic [7:0] i_max_length,
    input  wire logic [7:0] i_slot_count,
    output logic            o_res_valid,
    output t_result         o_res
);

    t_mode      r_mode,           n_mode;
    t_phase     r_phase,          n_phase;
    logic [7:0] r_byte_count,     n_byte_count;
    logic [7:0] r_id_accum,       n_id_accum;
    logic [7:0] r_size_accum,     n_size_accum;
    logic [7:0] r_payload_length, n_payload_length;
    logic [7:0] r_payload_id,     n_payload_id;

    logic       digit;
    logic [7:0] dval;
    logic [7:0] id_x10;
    logic [7:0] size_x10;
    logic [7:0] count_inc;
    logic [7:0] hdr_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= MODE_IDLE;
            r_phase          <= PH_ID;
            r_byte_count     <= '0;
            r_id_accum       <= '0;
            r_size_accum     <= '0;
            r_payload_length <= '0;
            r_payload_id     <= '0;
        end else if (i_accept) begin
            r_mode           <= n_mode;
            r_phase          <= n_phase;
            r_byte_count     <= n_byte_count;
            r_id_accum       <= n_id_accum;
            r_size_accum     <= n_size_accum;
            r_payload_length <= n_payload_length;
            r_payload_id     <= n_payload_id;
        end
    end

    assign digit     = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign dval      = i_rx_byte - CH_ZERO;
    // x*10 mod 256 as two shifts and an add
    assign id_x10    = {r_id_accum[4:0], 3'b000} + {r_id_accum[6:0], 1'b0} + dval;
    assign size_x10  = {r_size_accum[4:0], 3'b000} + {r_size_accum[6:0], 1'b0} + dval;
    assign count_inc = r_byte_count + 8'd1;
    // size only counts once the comma was seen
    assign hdr_size  = r_phase[1] ? r_size_accum : 8'd0;

    always_comb begin
        n_mode           = r_mode;
        n_phase          = r_phase;
        n_byte_count     = r_byte_count;
        n_id_accum       = r_id_accum;
        n_size_accum     = r_size_accum;
        n_payload_length = r_payload_length;
        n_payload_id     = r_payload_id;
        o_res_valid      = 1'b0;
        o_res            = '{data_byte: 8'd0, has_data: 1'b0, headered: 1'b0,
                             conn_id: 8'd0, status: ST_OK, last: 1'b0};

        unique case (r_mode)
            MODE_IDLE: begin
                if (i_max_length != 8'd0) begin
                    if (i_rx_byte == CH_LBRACE) begin
                        n_mode             = MODE_BRACE;
                        n_byte_count       = 8'd1;
                        o_res_valid        = 1'b1;
                        o_res.data_byte    = i_rx_byte;
                        o_res.has_data     = 1'b1;
                    end else if (i_rx_byte == CH_LT) begin
                        n_mode       = MODE_HEADER;
                        n_byte_count = 8'd1;
                        n_id_accum   = '0;
                        n_size_accum = '0;
                        n_phase      = PH_ID;
                    end
                end
            end

            MODE_BRACE: begin
                o_res_valid = 1'b1;
                if (r_byte_count >= i_max_length) begin
                    n_mode       = MODE_IDLE;
                    n_byte_count = '0;
                    o_res.status = ST_OVERFLOW;
                    o_res.last   = 1'b1;
                end else begin
                    n_byte_count    = count_inc;
                    o_res.data_byte = i_rx_byte;
                    o_res.has_data  = 1'b1;
                    if (i_rx_byte == CH_RBRACE) begin
                        n_mode       = MODE_IDLE;
                        n_byte_count = '0;
                        o_res.last   = 1'b1;
                    end
                end
            end

            MODE_HEADER: begin
                if (r_byte_count >= i_max_length) begin
                    n_mode         = MODE_IDLE;
                    n_byte_count   = '0;
                    o_res_valid    = 1'b1;
                    o_res.headered = 1'b1;
                    o_res.status   = ST_BAD_HEADER;
                    o_res.last     = 1'b1;
                end else if (i_rx_byte == CH_GT) begin
                    if ((r_id_accum < i_slot_count) && (hdr_size != 8'd0)
                            && (hdr_size < i_max_length)) begin
                        n_mode           = MODE_PAYLOAD;
                        n_byte_count     = '0;
                        n_payload_id     = r_id_accum;
                        n_payload_length = hdr_size;
                    end else begin
                        n_mode         = MODE_IDLE;
                        n_byte_count   = '0;
                        o_res_valid    = 1'b1;
                        o_res.headered = 1'b1;
                        o_res.status   = ST_BAD_HEADER;
                        o_res.last     = 1'b1;
                    end
                end else begin
                    n_byte_count = count_inc;
                    case (r_phase)
                        PH_ID: begin
                            if (digit) begin
                                n_id_accum = id_x10;
                            end else if (i_rx_byte == CH_COMMA) begin
                                n_phase = PH_SIZE;
                            end else begin
                                n_phase = PH_SKIP_ID;
                            end
                        end
                        PH_SKIP_ID: begin
                            if (i_rx_byte == CH_COMMA) begin
                                n_phase = PH_SIZE;
                            end
                        end
                        PH_SIZE: begin
                            if (digit) begin
                                n_size_accum = size_x10;
                            end else begin
                                n_phase = PH_SKIP_SZ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            MODE_PAYLOAD: begin
                n_byte_count    = count_inc;
                o_res_valid     = 1'b1;
                o_res.data_byte = i_rx_byte;
                o_res.has_data  = 1'b1;
                o_res.headered  = 1'b1;
                o_res.conn_id   = r_payload_id;
                if (count_inc >= r_payload_length) begin
                    n_mode       = MODE_IDLE;
                    n_byte_count = '0;
                    o_res.last   = 1'b1;
                end
            end

            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/serial_message_deframer_core.sv
// Top level of the serial message deframer: config registers, parser and output skid.
// Depends on smd_pkg and smd_parser.
//
// Splits a stream of received serial bytes into messages, one byte per input word.
// When idle, '{' opens a brace message whose bytes, both braces included, pass out as
// they arrive, with last set on '}'. '<' opens a header "<id,size>" with decimal id
// and size (mod 256); a valid header (id below slot_count, size from 1 to
// max_length-1) gives no result and makes the next size bytes pass out tagged with
// id, headered set. An overlong brace message ends with status 1, a bad or overlong
// header with status 2; both drop the offending byte and return to idle. Each input
// word produces zero or one output word. Throughput is one word per clock while
// o_in_stall is low: the parser updates its state when a word is accepted and the
// result is registered in the output register, or in the skid if output is stalled. A
// two-entry stage (output register plus skid) lets input flow on after output stalls
// until the skid fills; o_in_stall is a flop output. Configuration (APB, max_length
// at 0x0, slot_count at 0x4) must only be written while no message is in flight.
`default_nettype none

module serial_message_deframer_core
    import smd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // input byte channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_rx_byte,

    // output word channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_data_byte,
    output logic             o_has_data,
    output logic             o_headered,
    output logic [7:0]       o_conn_id,
    output logic [1:0]       o_status,
    output logic             o_last,

    // APB config port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0] r_max_length;
    logic [7:0] r_slot_count;

    logic       in_accept;
    logic       out_take;
    logic       res_valid;
    t_result    res;

    logic       r_out_valid;
    t_result    r_out;
    logic       r_skid_valid;
    t_result    r_skid;

    // ---------------- config registers ----------------
    assign pready = 1'b1;

    // only paddr[2] decodes; byte offsets paddr[1:0] are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RST;
            r_slot_count <= SLOT_COUNT_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_SLOT_COUNT) begin
                r_slot_count <= pwdata[7:0];
            end else begin
                r_max_length <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SLOT_COUNT) begin
            prdata[7:0] = r_slot_count;
        end else begin
            prdata[7:0] = r_max_length;
        end
    end

    // ---------------- parser ----------------
    // input only stalls once the skid entry is occupied
    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;

    smd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_rx_byte    (i_rx_byte),
        .i_max_length (r_max_length),
        .i_slot_count (r_slot_count),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // ---------------- output register + skid ----------------
    // skid fills only when a new result arrives while the output holds a stalled word;
    // while skid is full no input is accepted, so the two never load together.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (out_take) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (in_accept && res_valid) begin
                if (!r_out_valid || out_take) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (in_accept && res_valid) begin
            if (!r_out_valid || out_take) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_out.data_byte;
    assign o_has_data  = r_out.has_data;
    assign o_headered  = r_out.headered;
    assign o_conn_id   = r_out.conn_id;
    assign o_status    = r_out.status;
    assign o_last      = r_out.last;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for serial_message_deframer_core: byte stream in, message words out.
// Depends on smd_pkg and the deframer RTL; a built-in predictor models the parser state.
`default_nettype none

module tb_top;
    import smd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 500;
    localparam int DRAIN_PAD    = 4;   // margin after the expected words are out

    // one row of the directed sequence; typed rows carry their expected word
    typedef struct packed {
        logic [7:0] max_len;
        logic [7:0] rx;
        logic       typed;
        t_result    res;
    } t_step_row;

    localparam t_step_row DIRECTED [27] = '{
        // brace message with extreme bytes
        '{8'd250, CH_LBRACE, 1'b1, '{CH_LBRACE, 1'b1, 1'b0, 8'd0, ST_OK, 1'b0}},
        '{8'd250, 8'h00,     1'b1, '{8'h00, 1'b1, 1'b0, 8'd0, ST_OK, 1'b0}},
        '{8'd250, 8'hFF,     1'b1, '{8'hFF, 1'b1, 1'b0, 8'd0, ST_OK, 1'b0}},
        '{8'd250, CH_RBRACE, 1'b1, '{CH_RBRACE, 1'b1, 1'b0, 8'd0, ST_OK, 1'b1}},
        // <3,2> then two payload bytes on connection 3
        '{8'd250, CH_LT,             1'b0, '0},
        '{8'd250, CH_ZERO + 8'd3,    1'b0, '0},
        '{8'd250, CH_COMMA,          1'b0, '0},
        '{8'd250, CH_ZERO + 8'd2,    1'b0, '0},
        '{8'd250, CH_GT,             1'b0, '0},
        '{8'd250, 8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1, 8'd3, ST_OK, 1'b0}},
        '{8'd250, 8'h00, 1'b1, '{8'h00, 1'b1, 1'b1, 8'd3, ST_OK, 1'b1}},
        // id equal to slot count is rejected
        '{8'd250, CH_LT,             1'b0, '0},
        '{8'd250, CH_ZERO + 8'd4,    1'b0, '0},
        '{8'd250, CH_COMMA,          1'b0, '0},
        '{8'd250, CH_ZERO + 8'd1,    1'b0, '0},
        '{8'd250, CH_GT, 1'b1, '{8'h00, 1'b0, 1'b1, 8'd0, ST_BAD_HEADER, 1'b1}},
        // header without a comma reads size zero
        '{8'd250, CH_LT,             1'b0, '0},
        '{8'd250, CH_ZERO,           1'b0, '0},
        '{8'd250, CH_GT, 1'b1, '{8'h00, 1'b0, 1'b1, 8'd0, ST_BAD_HEADER, 1'b1}},
        // short limit: brace overflow, then header too long
        '{8'd3, CH_LBRACE, 1'b1, '{CH_LBRACE, 1'b1, 1'b0, 8'd0, ST_OK, 1'b0}},
        '{8'd3, 8'h61,     1'b0, '0},
        '{8'd3, 8'h62,     1'b0, '0},
        '{8'd3, 8'h63,     1'b1, '{8'h00, 1'b0, 1'b0, 8'd0, ST_OVERFLOW, 1'b1}},
        '{8'd3, CH_LT,             1'b0, '0},
        '{8'd3, CH_ZERO + 8'd1,    1'b0, '0},
        '{8'd3, CH_ZERO + 8'd2,    1'b0, '0},
        '{8'd3, CH_ZERO + 8'd3,    1'b1, '{8'h00, 1'b0, 1'b1, 8'd0, ST_BAD_HEADER, 1'b1}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_data_byte;
    logic        o_has_data;
    logic        o_headered;
    logic [7:0]  o_conn_id;
    logic [1:0]  o_status;
    logic        o_last;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    serial_message_deframer_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_byte (o_data_byte),
        .o_has_data  (o_has_data),
        .o_headered  (o_headered),
        .o_conn_id   (o_conn_id),
        .o_status    (o_status),
        .o_last      (o_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor copy of the registers and parser state
    logic [7:0] cfg_max_len = MAX_LENGTH_RST;
    logic [7:0] cfg_slots   = SLOT_COUNT_RST;
    t_mode      mode_q      = MODE_IDLE;
    t_phase     phase_q     = PH_ID;
    logic [7:0] byte_cnt    = 8'd0;
    logic [7:0] id_acc      = 8'd0;
    logic [7:0] size_acc    = 8'd0;
    logic [7:0] pay_len     = 8'd0;
    logic [7:0] pay_id      = 8'd0;

    t_result expected_words[$];
    int      words_in   = 0;
    int      mismatches = 0;
    bit      no_gaps    = 1'b0;   // stretch with no idling on either side

    // Advance the parser by one received byte; returns 1 when a word comes out.
    function automatic bit deframe_byte(input logic [7:0] c, output t_result res);
        bit         is_digit;
        logic [7:0] digit_val;
        logic [7:0] sz;
        is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
        digit_val = c - CH_ZERO;
        res = '0;
        case (mode_q)
            MODE_IDLE: begin
                if (cfg_max_len == 8'd0) return 1'b0;
                if (c == CH_LBRACE) begin
                    mode_q = MODE_BRACE;
                    byte_cnt = 8'd1;
                    res.data_byte = c;
                    res.has_data = 1'b1;
                    return 1'b1;
                end
                if (c == CH_LT) begin
                    mode_q = MODE_HEADER;
                    byte_cnt = 8'd1;
                    id_acc = 8'd0;
                    size_acc = 8'd0;
                    phase_q = PH_ID;
                end
                return 1'b0;
            end
            MODE_BRACE: begin
                if (byte_cnt >= cfg_max_len) begin
                    // offending byte is dropped
                    mode_q = MODE_IDLE;
                    byte_cnt = 8'd0;
                    res.status = ST_OVERFLOW;
                    res.last = 1'b1;
                    return 1'b1;
                end
                byte_cnt = byte_cnt + 8'd1;
                res.data_byte = c;
                res.has_data = 1'b1;
                if (c == CH_RBRACE) begin
                    mode_q = MODE_IDLE;
                    byte_cnt = 8'd0;
                    res.last = 1'b1;
                end
                return 1'b1;
            end
            MODE_HEADER: begin
                if (byte_cnt >= cfg_max_len) begin
                    mode_q = MODE_IDLE;
                    byte_cnt = 8'd0;
                    res.headered = 1'b1;
                    res.status = ST_BAD_HEADER;
                    res.last = 1'b1;
                    return 1'b1;
                end
                byte_cnt = byte_cnt + 8'd1;
                if (c == CH_GT) begin
                    sz = (phase_q == PH_SIZE || phase_q == PH_SKIP_SZ) ? size_acc : 8'd0;
                    if (id_acc < cfg_slots && sz >= 8'd1 && sz < cfg_max_len) begin
                        mode_q = MODE_PAYLOAD;
                        byte_cnt = 8'd0;
                        pay_id = id_acc;
                        pay_len = sz;
                        return 1'b0;
                    end
                    mode_q = MODE_IDLE;
                    byte_cnt = 8'd0;
                    res.headered = 1'b1;
                    res.status = ST_BAD_HEADER;
                    res.last = 1'b1;
                    return 1'b1;
                end
                case (phase_q)
                    PH_ID: begin
                        if (is_digit) id_acc = id_acc * 8'd10 + digit_val;
                        else if (c == CH_COMMA) phase_q = PH_SIZE;
                        else phase_q = PH_SKIP_ID;
                    end
                    PH_SKIP_ID: begin
                        if (c == CH_COMMA) phase_q = PH_SIZE;
                    end
                    PH_SIZE: begin
                        if (is_digit) size_acc = size_acc * 8'd10 + digit_val;
                        else phase_q = PH_SKIP_SZ;
                    end
                    default: ;
                endcase
                return 1'b0;
            end
            default: begin
                // payload keeps the size latched from its header
                byte_cnt = byte_cnt + 8'd1;
                res.data_byte = c;
                res.has_data = 1'b1;
                res.headered = 1'b1;
                res.conn_id = pay_id;
                if (byte_cnt >= pay_len) begin
                    mode_q = MODE_IDLE;
                    byte_cnt = 8'd0;
                    res.last = 1'b1;
                end
                return 1'b1;
            end
        endcase
    endfunction

    // Present one byte, hold it until accepted, then predict its word.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input t_result typed_res = '0);
        t_result res;
        bit      got;
        while (!no_gaps && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        // idle bytes other than openers are ignored and do not count
        if (mode_q != MODE_IDLE || b == CH_LBRACE || b == CH_LT) words_in++;
        got = deframe_byte(b, res);
        if (typed) expected_words.push_back(typed_res);
        else if (got) expected_words.push_back(res);
    endtask

    // Sender stops until every expected word is out, then waits out a margin.
    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAD) @(posedge i_clk);
    endtask

    task automatic set_register(input logic idx, input logic [7:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_MAX_LENGTH) cfg_max_len = val;
        else cfg_slots = val;
        @(posedge i_clk);
    endtask

    // Bring the parser back to idle so registers can be rewritten.
    task automatic close_message();
        while (mode_q != MODE_IDLE) send_byte(mode_q == MODE_HEADER ? CH_GT : CH_RBRACE);
    endtask

    // Decimal text; sometimes a leading zero or an offset of a multiple of 256 to hit the wrap.
    task automatic send_decimal(input int v);
        if ($urandom_range(99) < 15) v += 256 * int'($urandom_range(2, 1));
        if ($urandom_range(99) < 10) send_byte(CH_ZERO);
        if (v >= 100) send_byte(CH_ZERO + 8'(v / 100));
        if (v >= 10) send_byte(CH_ZERO + 8'((v / 10) % 10));
        send_byte(CH_ZERO + 8'(v % 10));
    endtask

    // filler that neither adds a digit nor moves the header on
    function automatic logic [7:0] rand_junk();
        logic [7:0] j;
        do j = 8'($urandom);
        while ((j >= CH_ZERO && j <= CH_NINE) || j == CH_COMMA || j == CH_GT);
        return j;
    endfunction

    task automatic send_random_message();
        int         kind;
        int         n;
        int         id_v;
        int         sz;
        int         lim;
        logic [7:0] b;
        kind = $urandom_range(99);
        lim = (cfg_max_len > 8'd13) ? 12 : int'(cfg_max_len) - 1;
        if (kind < 12) begin
            // line noise
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
        end else if (kind < 45) begin
            // brace message, now and then right at or past the limit
            if ($urandom_range(99) < 10) n = int'(cfg_max_len) - 3 + int'($urandom_range(3, 0));
            else n = int'($urandom_range((cfg_max_len > 8'd10) ? 10 : int'(cfg_max_len), 0));
            if (n < 0) n = 0;
            send_byte(CH_LBRACE);
            for (int k = 0; k < n; k++) begin
                b = 8'($urandom);
                if (b == CH_RBRACE && $urandom_range(7) != 0) b = 8'h20;
                send_byte(b);
            end
            send_byte(CH_RBRACE);
        end else if (kind < 88) begin
            // header and payload, mostly valid
            if ($urandom_range(99) < 80) id_v = int'($urandom_range(int'(cfg_slots) - 1, 0));
            else id_v = int'($urandom_range(255, 0));
            n = $urandom_range(99);
            if (n < 80) sz = int'($urandom_range(lim, 1));
            else if (n < 96) sz = int'($urandom_range(255, 0));
            else sz = int'(cfg_max_len) - 1 + int'($urandom_range(1, 0));
            send_byte(CH_LT);
            send_decimal(id_v);
            if ($urandom_range(99) < 10) repeat ($urandom_range(3, 1)) send_byte(rand_junk());
            if ($urandom_range(99) < 95) send_byte(CH_COMMA);
            send_decimal(sz);
            if ($urandom_range(99) < 10) repeat ($urandom_range(3, 1)) send_byte(rand_junk());
            send_byte(CH_GT);
            while (mode_q == MODE_PAYLOAD) send_byte(8'($urandom));
        end else begin
            // broken header
            send_byte(CH_LT);
            repeat ($urandom_range(6, 1)) send_byte(8'($urandom));
        end
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        i_out_stall <= !no_gaps && ($urandom_range(99) < 33);
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // compare each accepted word with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word: expected none, got data %0h status %0d last %0b",
                         $time, o_data_byte, o_status, o_last);
                mismatches++;
            end else begin
                want = expected_words.pop_front();
                check_field("data_byte", want.data_byte, o_data_byte);
                check_field("has_data", 8'(want.has_data), 8'(o_has_data));
                check_field("headered", 8'(want.headered), 8'(o_headered));
                check_field("conn_id", want.conn_id, o_conn_id);
                check_field("status", 8'(want.status), 8'(o_status));
                check_field("last", 8'(want.last), 8'(o_last));
            end
        end
    end

    initial begin : stimulus
        int         dir_words;
        int         goal;
        logic [7:0] ml;
        logic [7:0] sc;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < $size(DIRECTED); i++) begin
            if (DIRECTED[i].max_len != cfg_max_len) begin
                pause_until_drained();
                set_register(REG_MAX_LENGTH, DIRECTED[i].max_len);
            end
            send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].res);
        end
        dir_words = words_in;

        for (int p = 0; p < 8; p++) begin
            close_message();
            pause_until_drained();
            case (p)
                0: begin ml = 8'd2;   sc = 8'd1;   end
                1: begin ml = 8'd255; sc = 8'd255; end
                2: begin ml = 8'd8;   sc = 8'd2;   end
                3: begin ml = MAX_LENGTH_RST; sc = SLOT_COUNT_RST; end
                4: begin ml = 8'($urandom_range(20, 2));  sc = 8'($urandom_range(8, 1));   end
                5: begin ml = 8'($urandom_range(255, 2)); sc = 8'($urandom_range(255, 1)); end
                6: begin ml = 8'd20;  sc = 8'd10;  end
                default: begin ml = 8'($urandom_range(64, 12)); sc = 8'($urandom_range(255, 1)); end
            endcase
            no_gaps = (p == 3);
            set_register(REG_MAX_LENGTH, ml);
            set_register(REG_SLOT_COUNT, sc);
            goal = dir_words + (p + 1) * RANDOM_WORDS / 8;
            while (words_in < goal) begin
                send_random_message();
                if ($urandom_range(99) < 4) pause_until_drained();
            end
        end

        close_message();
        pause_until_drained();
        if (mismatches == 0) begin
            $display("** serial_message_deframer_core: PASSED **");
        end else begin
            $display("** serial_message_deframer_core: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #5ms;
        $display("** serial_message_deframer_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
